### hdl/apwb_pkg.sv
package apwb_pkg;

  // Defaults for the top-level geometry parameters
  localparam int unsigned ImageWidthDef   = 256;
  localparam int unsigned ImageHeightDef  = 256;
  localparam int unsigned MaxHalfPatchDef = 4;

  // Divider widths: numerator up to 2^37 in magnitude, |det| up to 2^31
  localparam int unsigned NumW = 40;
  localparam int unsigned DenW = 33;

  // Configuration port
  localparam int unsigned PaddrW = 4;
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_HALF = 2'd2;

  // Register reset values
  localparam logic [8:0] ColsRst = 9'd256;
  localparam logic [8:0] RowsRst = 9'd256;
  localparam logic [2:0] HalfRst = 3'd4;

  // Item actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_WARP  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [7:0]         pixel_col;
    logic [7:0]         pixel_row;
    logic [7:0]         pixel_value;
    logic signed [15:0] affine_00;
    logic signed [15:0] affine_01;
    logic signed [15:0] affine_10;
    logic signed [15:0] affine_11;
    logic [15:0]        key_x;
    logic [15:0]        key_y;
    logic [1:0]         ref_level;
    logic [1:0]         srch_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] patch_value;
    logic       failed;
    logic       last;
  } out_item_t;

endpackage

### hdl/apwb_if.sv
interface apwb_in_if;
  logic                valid;
  logic                ready;
  apwb_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apwb_out_if;
  logic                valid;
  logic                ready;
  apwb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/apwb_img_mem.sv
module apwb_img_mem #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/apwb_div.sv
module apwb_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [apwb_pkg::NumW-1:0]   num_i,
  input  logic signed [apwb_pkg::DenW-1:0]   den_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic signed [apwb_pkg::NumW-1:0]   quot_o
);

  localparam int unsigned NW = apwb_pkg::NumW;
  localparam int unsigned DW = apwb_pkg::DenW;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [NW-1:0] q_q, q_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dmag_q, dmag_d;
  logic          neg_q, neg_d;
  logic [DW-1:0] trial;

  // One quotient bit per cycle, restoring on magnitudes
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    q_d    = q_q;
    rem_d  = rem_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    trial  = {rem_q[DW-2:0], q_q[NW-1]};
    if (start_i) begin
      q_d    = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      dmag_d = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      neg_d  = num_i[NW-1] ^ den_i[DW-1];
      rem_d  = '0;
      cnt_d  = CW'(NW);
    end else if (cnt_q != '0) begin
      if (trial >= dmag_q) begin
        rem_d = trial - dmag_q;
        q_d   = {q_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        q_d   = {q_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    rem_q  <= rem_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
  end

  // Floor towards minus infinity when the signs differ
  assign quot_o = neg_q ? (-$signed(q_q) - ((rem_q != '0) ? NW'(1) : NW'(0)))
                        : $signed(q_q);
  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;

endmodule

### hdl/affine_patch_warp_bilinear.sv
// Affine patch warp with bilinear sampling.
//
// Input channel in_i carries two kinds of item. A write item (action 0)
// stores one pixel byte in the image memory in the cycle it is accepted and
// gives no result. A warp item (action 1) inverts its 2x2 matrix and emits
// (2*half_patch)^2 interpolated bytes in raster order on out_o, last set on
// the final one, or stops early with one result marked failed and last.
// A singular matrix gives a single failed result. A write item outside
// cols by rows is dropped. Write items are accepted back to back while
// no warp is in progress. A warp item runs a set-up of products,
// determinant and singularity check, then for each sample the two serial
// dividers, which run side by side at one quotient bit a cycle, the bounds
// check, the address, four pixel reads through the single memory read port
// and the emit step. in_i is not ready while a warp item is in progress.
// Results leave through a one-item output register; a stalled receiver
// holds the sequencer in its emit step and nothing is dropped.
// Reset returns the sequencer to idle and the registers to cols 256,
// rows 256, half_patch 4; image contents are undefined until written.
// Write the APB-style configuration registers only while no warp is running.
module affine_patch_warp_bilinear #(
  parameter int unsigned IMAGE_WIDTH    = apwb_pkg::ImageWidthDef,
  parameter int unsigned IMAGE_HEIGHT   = apwb_pkg::ImageHeightDef,
  parameter int unsigned MAX_HALF_PATCH = apwb_pkg::MaxHalfPatchDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  apwb_in_if.sink                       in_i,
  apwb_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apwb_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned Depth = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned NW    = apwb_pkg::NumW;
  localparam int unsigned DW    = apwb_pkg::DenW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DET, ST_CHK, ST_NUM, ST_DIVS, ST_DIVW,
    ST_BND, ST_ADDR, ST_RD, ST_EMIT
  } state_e;

  // Configuration registers
  logic [8:0] cols_cfg_q, rows_cfg_q;
  logic [2:0] half_cfg_q;
  logic       cfg_we;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= apwb_pkg::ColsRst;
      rows_cfg_q <= apwb_pkg::RowsRst;
      half_cfg_q <= apwb_pkg::HalfRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        apwb_pkg::REG_COLS: cols_cfg_q <= pwdata[8:0];
        apwb_pkg::REG_ROWS: rows_cfg_q <= pwdata[8:0];
        apwb_pkg::REG_HALF: half_cfg_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      apwb_pkg::REG_COLS: prdata = {23'd0, cols_cfg_q};
      apwb_pkg::REG_ROWS: prdata = {23'd0, rows_cfg_q};
      apwb_pkg::REG_HALF: prdata = {29'd0, half_cfg_q};
      default:            prdata = '0;
    endcase
  end

  // Effective geometry
  logic [8:0] cols, rows;
  logic [2:0] hsat;
  assign cols = (32'(cols_cfg_q) > IMAGE_WIDTH)  ? 9'(IMAGE_WIDTH)  : cols_cfg_q;
  assign rows = (32'(rows_cfg_q) > IMAGE_HEIGHT) ? 9'(IMAGE_HEIGHT) : rows_cfg_q;
  assign hsat = (half_cfg_q == 3'd0) ? 3'd1 :
                (32'(half_cfg_q) > MAX_HALF_PATCH) ? 3'(MAX_HALF_PATCH) : half_cfg_q;

  // State
  state_e                state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  apwb_pkg::out_item_t   out_q, out_d;
  logic signed [15:0]    a00_q, a01_q, a10_q, a11_q;
  logic signed [15:0]    a00_d, a01_d, a10_d, a11_d;
  logic [19:0]           kx8_q, ky8_q, kx8_d, ky8_d;
  logic [1:0]            sl_q, sl_d;
  logic [2:0]            h_q, h_d;
  logic signed [3:0]     x_q, y_q, x_d, y_d;
  logic signed [31:0]    prod0_q, prod1_q, prod0_d, prod1_d;
  logic signed [DW-1:0]  det_q, det_d;
  logic signed [NW-1:0]  numx_q, numy_q, numx_d, numy_d;
  logic signed [NW:0]    px_q, py_q, px_d, py_d;
  logic [8:0]            xi_q, yi_q, xi_d, yi_d;
  logic [7:0]            fx_q, fy_q, fx_d, fy_d;
  logic [AW-1:0]         base_q, base_d;
  logic [2:0]            k_q, k_d;
  logic [16:0]           wgt_q, wgt_d;
  logic [23:0]           acc_q, acc_d;
  logic                  fail_q, fail_d;

  // Memory and divider hookup
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_rdata;
  logic          div_start, divx_busy, divy_busy, divx_done, divy_done;
  logic signed [NW-1:0] qx, qy;

  logic                 in_acc, slot_free, last_smp;
  logic signed [3:0]    hs;
  logic signed [20:0]   tx, ty;
  logic [32:0]          xw, yw;
  logic [8:0]           fxs, fys;

  assign in_acc    = in_i.valid & in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign hs        = $signed({1'b0, h_q});
  assign last_smp  = (x_q == hs - 4'sd1) && (y_q == hs - 4'sd1);
  assign div_start = (state_q == ST_DIVS);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Pixel write straight from the accepted item
  assign mem_we = in_acc && (in_i.data.action == apwb_pkg::ACT_WRITE)
                  && ({1'b0, in_i.data.pixel_col} < cols)
                  && ({1'b0, in_i.data.pixel_row} < rows);
  assign mem_waddr = AW'(18'(in_i.data.pixel_row) * 18'(cols)
                         + 18'(in_i.data.pixel_col));

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    a00_d = a00_q; a01_d = a01_q; a10_d = a10_q; a11_d = a11_q;
    kx8_d = kx8_q; ky8_d = ky8_q; sl_d = sl_q; h_d = h_q;
    x_d = x_q; y_d = y_q;
    prod0_d = prod0_q; prod1_d = prod1_q; det_d = det_q;
    numx_d = numx_q; numy_d = numy_q; px_d = px_q; py_d = py_q;
    xi_d = xi_q; yi_d = yi_q; fx_d = fx_q; fy_d = fy_q;
    base_d = base_q; k_d = k_q; wgt_d = wgt_q; acc_d = acc_q; fail_d = fail_q;
    mem_re    = 1'b0;
    mem_raddr = base_q;
    tx  = a11_q * x_q - a01_q * y_q;
    ty  = a00_q * y_q - a10_q * x_q;
    xw  = 33'(px_q[NW-1:8]) + 33'd1;
    yw  = 33'(py_q[NW-1:8]) + 33'd1;
    fxs = (k_q < 3'd2) ? (9'd256 - 9'(fx_q)) : {1'b0, fx_q};
    fys = (k_q == 3'd0 || k_q == 3'd2) ? (9'd256 - 9'(fy_q)) : {1'b0, fy_q};

    case (state_q)
      ST_IDLE: begin
        // Latch a warp item
        if (in_acc && in_i.data.action == apwb_pkg::ACT_WARP) begin
          a00_d = in_i.data.affine_00;
          a01_d = in_i.data.affine_01;
          a10_d = in_i.data.affine_10;
          a11_d = in_i.data.affine_11;
          kx8_d = {in_i.data.key_x, 4'b0} >> in_i.data.ref_level;
          ky8_d = {in_i.data.key_y, 4'b0} >> in_i.data.ref_level;
          sl_d  = in_i.data.srch_level;
          h_d   = hsat;
          x_d   = -$signed({1'b0, hsat});
          y_d   = -$signed({1'b0, hsat});
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod0_d = a00_q * a11_q;
        prod1_d = a01_q * a10_q;
        state_d = ST_DET;
      end
      ST_DET: begin
        det_d   = DW'(prod0_q) - DW'(prod1_q);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        fail_d  = (det_q == '0);
        state_d = (det_q == '0) ? ST_EMIT : ST_NUM;
      end
      ST_NUM: begin
        // Offset times the adjugate, scaled to the search level
        numx_d  = NW'(tx) <<< (5'd16 + 5'(sl_q));
        numy_d  = NW'(ty) <<< (5'd16 + 5'(sl_q));
        state_d = ST_DIVS;
      end
      ST_DIVS: begin
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (divx_done) begin
          px_d    = (NW + 1)'(qx) + $signed({(NW - 19)'(0), kx8_q});
          py_d    = (NW + 1)'(qy) + $signed({(NW - 19)'(0), ky8_q});
          state_d = ST_BND;
        end
      end
      ST_BND: begin
        // Check the 2x2 neighbourhood against the image
        fail_d = px_q[NW] || py_q[NW] || (xw >= 33'(cols)) || (yw >= 33'(rows));
        xi_d   = px_q[16:8];
        yi_d   = py_q[16:8];
        fx_d   = px_q[7:0];
        fy_d   = py_q[7:0];
        state_d = fail_d ? ST_EMIT : ST_ADDR;
      end
      ST_ADDR: begin
        base_d  = AW'(18'(yi_q) * 18'(cols) + 18'(xi_q));
        k_d     = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        // Issue one read and one weight per cycle, accumulate them in the next cycle
        case (k_q)
          3'd0:    mem_raddr = base_q;
          3'd1:    mem_raddr = base_q + AW'(cols);
          3'd2:    mem_raddr = base_q + AW'(1);
          default: mem_raddr = base_q + AW'(cols) + AW'(1);
        endcase
        mem_re = (k_q < 3'd4);
        wgt_d  = 17'(fxs * fys);
        if (k_q == 3'd0) begin
          acc_d = '0;
        end else begin
          acc_d = acc_q + 24'(wgt_q * mem_rdata);
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.patch_value = fail_q ? 8'd0 : acc_q[23:16];
          out_d.failed      = fail_q;
          out_d.last        = fail_q || last_smp;
          if (fail_q || last_smp) begin
            state_d = ST_IDLE;
          end else begin
            if (x_q == hs - 4'sd1) begin
              x_d = -hs;
              y_d = y_q + 4'sd1;
            end else begin
              x_d = x_q + 4'sd1;
            end
            state_d = ST_NUM;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a00_q <= a00_d; a01_q <= a01_d; a10_q <= a10_d; a11_q <= a11_d;
    kx8_q <= kx8_d; ky8_q <= ky8_d; sl_q <= sl_d; h_q <= h_d;
    x_q <= x_d; y_q <= y_d;
    prod0_q <= prod0_d; prod1_q <= prod1_d; det_q <= det_d;
    numx_q <= numx_d; numy_q <= numy_d; px_q <= px_d; py_q <= py_d;
    xi_q <= xi_d; yi_q <= yi_d; fx_q <= fx_d; fy_q <= fy_d;
    base_q <= base_d; k_q <= k_d; wgt_q <= wgt_d; acc_q <= acc_d;
    fail_q <= fail_d;
  end

  apwb_img_mem #(
    .Depth (Depth),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.data.pixel_value),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  apwb_div u_divx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (numx_q),
    .den_i   (det_q),
    .busy_o  (divx_busy),
    .done_o  (divx_done),
    .quot_o  (qx)
  );

  apwb_div u_divy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (numy_q),
    .den_i   (det_q),
    .busy_o  (divy_busy),
    .done_o  (divy_done),
    .quot_o  (qy)
  );

  // Checks
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.failed |-> out_q.patch_value == 8'd0 && out_q.last)
    else $error("failed item with nonzero value or without last");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !divx_busy && !divy_busy)
    else $error("divider started while busy");

  a_div_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divx_done == divy_done)
    else $error("dividers out of step");

  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re)
    else $error("image write during a sample read");

  a_warp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.data.action == apwb_pkg::ACT_WARP |=> !in_i.ready)
    else $error("input still ready after a warp item");

endmodule
